// ===== rtl/core/ast_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_pkg: shared definitions for the assembler source tokenizer
// Character codes, token kinds, scanner modes and the token word layout.
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int COUNTER_BITS = 16;
  localparam int OFFSET_BITS  = 24;
  localparam int VALUE_BITS   = 31;
  localparam int BYTE_BITS    = 8;

  localparam logic [COUNTER_BITS-1:0] COUNT_MAX = '1;
  localparam logic [VALUE_BITS-1:0]   VALUE_MAX = '1;

  // Output queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FILL_BITS  = $clog2(FIFO_DEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LD    = 8'h64;
  localparam logic [7:0] CH_LF_A  = 8'h66;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LT    = 8'h74;
  localparam logic [7:0] CH_LV    = 8'h76;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7a;

  typedef enum logic [3:0] {
    KIND_COLON    = 4'd0,
    KIND_COMMA    = 4'd1,
    KIND_NUMBER   = 4'd2,
    KIND_TEXT     = 4'd3,
    KIND_REG_I    = 4'd4,
    KIND_REG_DT   = 4'd5,
    KIND_REG_ST   = 4'd6,
    KIND_VARIABLE = 4'd7,
    KIND_END      = 4'd8,
    KIND_ERROR    = 4'd9
  } token_kind_t;

  typedef enum logic [7:0] {
    MODE_IDLE    = 8'b0000_0001,
    MODE_COMMENT = 8'b0000_0010,
    MODE_ZERO    = 8'b0000_0100,
    MODE_DEC     = 8'b0000_1000,
    MODE_HEX     = 8'b0001_0000,
    MODE_BIN     = 8'b0010_0000,
    MODE_NAME    = 8'b0100_0000,
    MODE_HALT    = 8'b1000_0000
  } scan_mode_t;

  typedef struct packed {
    token_kind_t             kind;
    logic [COUNTER_BITS-1:0] line;
    logic [COUNTER_BITS-1:0] column;
    logic [OFFSET_BITS-1:0]  offset;
    logic [COUNTER_BITS-1:0] length;
    logic [VALUE_BITS-1:0]   value;
    logic                    last;
  } token_t;

  // Tokens caused by one source byte: a closed number or name first, then
  // the token that the byte itself makes.
  typedef struct packed {
    logic   first_valid;
    token_t first_tok;
    logic   second_valid;
    token_t second_tok;
  } token_pair_t;

  // Value of a hex digit character; letters map through their low nibble.
  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      v = ch[3:0];
    end else begin
      v = ch[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/ast_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ast_scanner: per-byte scanner state and token formation
// Consumes one source byte per step and reports up to two tokens.
// ----------------------------------------------------------------------------
module ast_scanner
  import ast_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  step_byte,
  output token_pair_t tokens
);

  scan_mode_t              mode_r, mode_nxt;
  logic [COUNTER_BITS-1:0] line_r, line_nxt;
  logic [COUNTER_BITS-1:0] column_r, column_nxt;
  logic [OFFSET_BITS-1:0]  offset_r, offset_nxt;
  logic [COUNTER_BITS-1:0] start_line_r, start_line_nxt;
  logic [COUNTER_BITS-1:0] start_column_r, start_column_nxt;
  logic [OFFSET_BITS-1:0]  start_offset_r, start_offset_nxt;
  logic [COUNTER_BITS-1:0] span_r, span_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [15:0]             name_chars_r, name_chars_nxt;

  logic [7:0] b;
  logic       is_dec, is_lhex, is_uhex, is_bin, is_name_byte, is_name_start;
  logic       digit_ok;
  logic [3:0] digit;
  logic [VALUE_BITS+4:0] acc_scaled;
  logic [VALUE_BITS+4:0] acc_sum;

  assign b             = step_byte;
  assign is_dec        = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_lhex       = (b >= CH_LA) && (b <= CH_LF_A);
  assign is_uhex       = (b >= CH_UA) && (b <= CH_UF);
  assign is_bin        = (b == CH_ZERO) || (b == CH_ONE);
  assign is_name_start = ((b >= CH_LA) && (b <= CH_LZ)) || (b == CH_UNDER);
  assign is_name_byte  = is_name_start || is_dec;
  assign digit         = hex_value(b);

  // Multiply by the radix of the current mode using shifts and one add.
  always_comb begin
    if (mode_r == MODE_HEX) begin
      acc_scaled = {1'b0, acc_r, 4'b0000};
      digit_ok   = is_dec || is_lhex || is_uhex;
    end else if (mode_r == MODE_BIN) begin
      acc_scaled = {4'b0000, acc_r, 1'b0};
      digit_ok   = is_bin;
    end else begin
      acc_scaled = {2'b00, acc_r, 3'b000} + {4'b0000, acc_r, 1'b0};
      digit_ok   = is_dec;
    end
    acc_sum = acc_scaled + {{(VALUE_BITS+1){1'b0}}, digit};
  end

  always_comb begin
    logic       grow;
    logic       accumulate;
    logic       advance;
    logic       restart;
    logic       pending;
    logic       idle_handling;
    logic [7:0] c0;
    logic [7:0] c1;
    logic       c1_var;

    grow          = 1'b0;
    accumulate    = 1'b0;
    advance       = 1'b0;
    restart       = 1'b0;
    pending       = 1'b0;
    idle_handling = 1'b0;
    c0            = '0;
    c1            = '0;
    c1_var        = 1'b0;

    mode_nxt         = mode_r;
    line_nxt         = line_r;
    column_nxt       = column_r;
    offset_nxt       = offset_r;
    start_line_nxt   = start_line_r;
    start_column_nxt = start_column_r;
    start_offset_nxt = start_offset_r;
    span_nxt         = span_r;
    acc_nxt          = acc_r;
    ovf_nxt          = ovf_r;
    name_chars_nxt   = name_chars_r;
    tokens           = '0;

    unique case (mode_r)
      MODE_HALT: begin
        if (b == CH_NUL) begin
          tokens.second_valid      = 1'b1;
          tokens.second_tok.kind   = KIND_END;
          tokens.second_tok.line   = line_r;
          tokens.second_tok.column = column_r;
          tokens.second_tok.offset = offset_r;
          restart                  = 1'b1;
          mode_nxt                 = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (b == CH_CR || b == CH_LF || b == CH_NUL) begin
          mode_nxt      = MODE_IDLE;
          idle_handling = 1'b1;
        end else begin
          advance = 1'b1;
        end
      end
      MODE_ZERO: begin
        if (b == CH_LX || b == CH_LB) begin
          mode_nxt = (b == CH_LX) ? MODE_HEX : MODE_BIN;
          span_nxt = '0;
          advance  = 1'b1;
        end else if (is_dec) begin
          mode_nxt   = MODE_DEC;
          accumulate = 1'b1;
          grow       = 1'b1;
          advance    = 1'b1;
        end else begin
          pending       = 1'b1;
          idle_handling = 1'b1;
        end
      end
      MODE_DEC, MODE_HEX, MODE_BIN: begin
        if (digit_ok) begin
          accumulate = 1'b1;
          grow       = 1'b1;
          advance    = 1'b1;
        end else begin
          pending       = 1'b1;
          idle_handling = 1'b1;
        end
      end
      MODE_NAME: begin
        if (is_name_byte) begin
          if (span_r == COUNTER_BITS'(1)) begin
            name_chars_nxt[7:0] = b;
          end
          grow    = 1'b1;
          advance = 1'b1;
        end else begin
          pending       = 1'b1;
          idle_handling = 1'b1;
        end
      end
      default: begin
        idle_handling = 1'b1;
      end
    endcase

    if (grow && span_r != COUNT_MAX) begin
      span_nxt = span_r + COUNTER_BITS'(1);
    end

    if (accumulate && !ovf_r) begin
      if (acc_sum > {5'b00000, VALUE_MAX}) begin
        ovf_nxt = 1'b1;
        acc_nxt = '0;
      end else begin
        acc_nxt = acc_sum[VALUE_BITS-1:0];
      end
    end

    // A number or name closed by this byte.
    if (pending) begin
      mode_nxt                = MODE_IDLE;
      c0                      = name_chars_r[15:8];
      c1                      = name_chars_r[7:0];
      c1_var                  = ((c1 >= CH_ZERO) && (c1 <= CH_NINE)) ||
                                ((c1 >= CH_LA) && (c1 <= CH_LF_A));
      tokens.first_valid      = 1'b1;
      tokens.first_tok.line   = start_line_r;
      tokens.first_tok.column = start_column_r;
      tokens.first_tok.offset = start_offset_r;
      tokens.first_tok.length = span_r;
      if (mode_r == MODE_NAME) begin
        tokens.first_tok.kind = KIND_TEXT;
        if (span_r == COUNTER_BITS'(1) && c0 == CH_LI) begin
          tokens.first_tok.kind = KIND_REG_I;
        end else if (span_r == COUNTER_BITS'(2) && c0 == CH_LD && c1 == CH_LT) begin
          tokens.first_tok.kind = KIND_REG_DT;
        end else if (span_r == COUNTER_BITS'(2) && c0 == CH_LS && c1 == CH_LT) begin
          tokens.first_tok.kind = KIND_REG_ST;
        end else if (span_r == COUNTER_BITS'(2) && c0 == CH_LV && c1_var) begin
          tokens.first_tok.kind  = KIND_VARIABLE;
          tokens.first_tok.value = VALUE_BITS'(hex_value(c1));
        end
      end else begin
        tokens.first_tok.kind  = KIND_NUMBER;
        tokens.first_tok.value = ovf_r ? '0 : acc_r;
      end
    end

    // The byte handled on its own from the idle mode.
    if (idle_handling) begin
      tokens.second_tok.line   = line_r;
      tokens.second_tok.column = column_r;
      tokens.second_tok.offset = offset_r;
      if (b == CH_NUL) begin
        tokens.second_valid    = 1'b1;
        tokens.second_tok.kind = KIND_END;
        restart                = 1'b1;
      end else if (b == CH_SEMI) begin
        mode_nxt = MODE_COMMENT;
        advance  = 1'b1;
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF) begin
        advance = 1'b1;
      end else if (b == CH_COLON || b == CH_COMMA) begin
        tokens.second_valid      = 1'b1;
        tokens.second_tok.kind   = (b == CH_COLON) ? KIND_COLON : KIND_COMMA;
        tokens.second_tok.length = COUNTER_BITS'(1);
        advance                  = 1'b1;
      end else if (is_dec || is_name_start) begin
        start_line_nxt   = line_r;
        start_column_nxt = column_r;
        start_offset_nxt = offset_r;
        span_nxt         = COUNTER_BITS'(1);
        ovf_nxt          = 1'b0;
        advance          = 1'b1;
        if (is_dec) begin
          acc_nxt        = VALUE_BITS'(b[3:0]);
          name_chars_nxt = '0;
          mode_nxt       = (b == CH_ZERO) ? MODE_ZERO : MODE_DEC;
        end else begin
          acc_nxt        = '0;
          name_chars_nxt = {b, 8'h00};
          mode_nxt       = MODE_NAME;
        end
      end else begin
        tokens.second_valid      = 1'b1;
        tokens.second_tok.kind   = KIND_ERROR;
        tokens.second_tok.length = COUNTER_BITS'(1);
        mode_nxt                 = MODE_HALT;
      end
    end

    tokens.first_tok.last  = !tokens.second_valid;
    tokens.second_tok.last = 1'b1;

    if (restart) begin
      line_nxt   = COUNTER_BITS'(1);
      column_nxt = COUNTER_BITS'(1);
      offset_nxt = '0;
    end else if (advance) begin
      offset_nxt = offset_r + OFFSET_BITS'(1);
      if (b == CH_LF) begin
        column_nxt = COUNTER_BITS'(1);
        if (line_r != COUNT_MAX) begin
          line_nxt = line_r + COUNTER_BITS'(1);
        end
      end else if (column_r != COUNT_MAX) begin
        column_nxt = column_r + COUNTER_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      line_r         <= COUNTER_BITS'(1);
      column_r       <= COUNTER_BITS'(1);
      offset_r       <= '0;
      start_line_r   <= COUNTER_BITS'(1);
      start_column_r <= COUNTER_BITS'(1);
      start_offset_r <= '0;
      span_r         <= '0;
      acc_r          <= '0;
      ovf_r          <= 1'b0;
      name_chars_r   <= '0;
    end else if (step) begin
      mode_r         <= mode_nxt;
      line_r         <= line_nxt;
      column_r       <= column_nxt;
      offset_r       <= offset_nxt;
      start_line_r   <= start_line_nxt;
      start_column_r <= start_column_nxt;
      start_offset_r <= start_offset_nxt;
      span_r         <= span_nxt;
      acc_r          <= acc_nxt;
      ovf_r          <= ovf_nxt;
      name_chars_r   <= name_chars_nxt;
    end
  end

endmodule

// ===== rtl/core/assembler_source_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembler_source_tokenizer_unit: assembler source tokenizer top level
// Turns a stream of source bytes into colon, comma, number, name, end and
// error tokens with their source positions.
// ----------------------------------------------------------------------------
// The block takes one source byte per clock cycle while the input is ready and
// the scanner updates its state in that same cycle; the tokens a byte causes
// are written into a four-word output queue and reach the output port once
// the words ahead of them have left. A byte that closes a pending number or
// name and is itself a token (for example "r1," or "x:") makes two words, and
// the output port moves one word per cycle while the sink accepts, so the
// sustained input rate is one byte per cycle as long as tokens average at
// most one per byte and the sink keeps up. The input is ready whenever the
// queue has room for two words. A zero byte ends the source, gives an end
// word and restarts the line and column counts at 1 and the offset at 0. An
// invalid byte gives an error word and the block then drops every nonzero
// byte until a zero byte arrives. Numbers above 2^31-1 are reported with
// value 0. Nothing needs a clearing pass after reset.
// ----------------------------------------------------------------------------
module assembler_source_tokenizer_unit
  import ast_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // source_byte[7:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // token_line[15:0], token_column[31:16],
                                   // token_offset[55:32], token_length[71:56],
                                   // token_value[102:72], zero pad [103]
  output logic [3:0]   out_tuser,  // token_kind[3:0]
  output logic         out_tlast   // last_of_run
);

  logic        in_fire;
  logic        out_fire;
  token_pair_t tokens;

  // Output queue of token words.
  token_t                fifo_mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FILL_BITS-1:0]  fill_r, fill_nxt;
  logic [FILL_BITS-1:0]  push_count;
  logic                  push_first, push_second;
  token_t                push_word0, push_word1;
  token_t                head_word;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Accept only when two words are guaranteed to fit.
  assign in_tready = (fill_r <= FILL_BITS'(FIFO_DEPTH - 2));

  ast_scanner u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_fire),
    .step_byte (in_tdata),
    .tokens    (tokens)
  );

  // Pack the valid tokens so that the first valid one lands at the write pointer.
  always_comb begin
    push_first  = in_fire && (tokens.first_valid || tokens.second_valid);
    push_second = in_fire && tokens.first_valid && tokens.second_valid;
    push_word0  = tokens.first_valid ? tokens.first_tok : tokens.second_tok;
    push_word1  = tokens.second_tok;
    push_count  = FILL_BITS'(push_first) + FILL_BITS'(push_second);
    wr_ptr_nxt  = wr_ptr_r + PTR_BITS'(push_count);
    rd_ptr_nxt  = out_fire ? rd_ptr_r + PTR_BITS'(1) : rd_ptr_r;
    fill_nxt    = fill_r + push_count - FILL_BITS'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (push_first) begin
      fifo_mem_r[wr_ptr_r] <= push_word0;
    end
    if (push_second) begin
      fifo_mem_r[wr_ptr_r + PTR_BITS'(1)] <= push_word1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  assign head_word  = fifo_mem_r[rd_ptr_r];
  assign out_tvalid = (fill_r != '0);
  assign out_tuser  = head_word.kind;
  assign out_tlast  = head_word.last;
  assign out_tdata  = {1'b0, head_word.value, head_word.length, head_word.offset,
                       head_word.column, head_word.line};

  // The queue never holds more words than it has entries.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_BITS'(FIFO_DEPTH))
    else $error("output queue overfilled");

  // A byte that makes two tokens leaves a word waiting in the next cycle.
  a_pair_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && tokens.first_valid && tokens.second_valid) |=> out_tvalid)
    else $error("token pair lost in output queue");

  // End and error tokens are always the final word of their byte.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == KIND_END || out_tuser == KIND_ERROR)) |-> out_tlast)
    else $error("end or error token not marked last");

endmodule
